// ----- src/mvmb_pkg.sv -----
`timescale 1ns / 1ps

package mvmb_pkg;

   localparam int MAX_ROWS_DEFAULT = 64;
   localparam int MAX_COLS_DEFAULT = 256;

   localparam int CMD_W    = 2;
   localparam int ROW_W    = 6;
   localparam int COL_W    = 8;
   localparam int VAL_W    = 16;
   localparam int ACC_W    = 48;
   localparam int PROD_W   = 2 * VAL_W;
   localparam int FRAC_W   = 8;
   localparam int NROWS_W  = 7;
   localparam int NCOLS_W  = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   localparam logic [CMD_W-1:0] CMD_WEIGHT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_BIAS   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_VECTOR = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_IN_USE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_IN_USE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS_ENABLE = 2'd2;

   localparam logic [NROWS_W-1:0] ROWS_RESET = 7'd64;
   localparam logic [NCOLS_W-1:0] COLS_RESET = 9'd256;

   typedef struct packed {
      logic [CMD_W-1:0]        cmd;
      logic [ROW_W-1:0]        row_index;
      logic [COL_W-1:0]        col_index;
      logic signed [VAL_W-1:0] value;
      logic                    last;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0]        out_row;
      logic signed [VAL_W-1:0] result_value;
      logic                    last_of_run;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_OUT_READ,
      ST_OUT_LOAD
   } state_type;

   typedef struct packed {
      logic             mac_rd;
      logic             out_rd;
      logic             out_load;
      logic             last_row;
      logic             clear_sums;
      logic [ROW_W-1:0] row;
   } ctrl_type;

   typedef struct packed {
      logic pipe_busy;
      logic out_free;
   } stat_type;

endpackage

// ----- src/mvmb_ram.sv -----
`timescale 1ns / 1ps

module mvmb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- src/mvmb_datapath.sv -----
`timescale 1ns / 1ps

module mvmb_datapath #(
   parameter int MAX_ROWS = mvmb_pkg::MAX_ROWS_DEFAULT,
   parameter int MAX_COLS = mvmb_pkg::MAX_COLS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_acc,
   input  mvmb_pkg::req_type  req_data,
   input  logic               bias_en,
   input  mvmb_pkg::ctrl_type ctrl,
   output mvmb_pkg::stat_type stat,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output mvmb_pkg::rsp_type  rsp_data
);

   localparam int W_DEPTH = MAX_ROWS * MAX_COLS;
   localparam int WA_W    = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
   localparam int RA_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int VAL_W   = mvmb_pkg::VAL_W;
   localparam int ACC_W   = mvmb_pkg::ACC_W;
   localparam int PROD_W  = mvmb_pkg::PROD_W;
   localparam int FRAC_W  = mvmb_pkg::FRAC_W;
   localparam int FIN_W   = ACC_W + 1;
   localparam int Q_W     = FIN_W - FRAC_W;

   logic                      row_ok;
   logic                      col_ok;
   logic                      w_we;
   logic                      b_we;
   logic [WA_W-1:0]           w_waddr;
   logic [WA_W-1:0]           w_raddr;
   logic [VAL_W-1:0]          w_rdata;
   logic [VAL_W-1:0]          b_rdata;
   logic [ACC_W-1:0]          s_rdata;
   logic [ACC_W-1:0]          s_wdata;
   logic                      s_re;
   logic [RA_W-1:0]           rd_row;

   logic signed [VAL_W-1:0]   x_ff;
   logic [mvmb_pkg::COL_W-1:0] col_ff;
   logic [MAX_ROWS-1:0]       sum_vld_ff;
   logic [MAX_ROWS-1:0]       sum_vld_in;
   logic                      sum_ok_ff;
   logic                      s1_vld_ff;
   logic [RA_W-1:0]           s1_row_ff;
   logic                      s2_vld_ff;
   logic [RA_W-1:0]           s2_row_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [PROD_W-1:0]  prod_in;
   logic [ACC_W-1:0]          acc_ff;
   logic [ACC_W-1:0]          sum_sel;

   logic signed [FIN_W-1:0]   fin_sum;
   logic signed [FIN_W-1:0]   fin_bias;
   logic signed [Q_W-1:0]     q_val;
   logic [VAL_W-1:0]          sat_val;

   logic                      rsp_vld_ff;
   logic                      rsp_vld_in;
   mvmb_pkg::rsp_type         rsp_ff;

   assign row_ok  = int'(req_data.row_index) < MAX_ROWS;
   assign col_ok  = int'(req_data.col_index) < MAX_COLS;
   assign w_we    = req_acc && req_data.cmd == mvmb_pkg::CMD_WEIGHT && row_ok && col_ok;
   assign b_we    = req_acc && req_data.cmd == mvmb_pkg::CMD_BIAS && row_ok;
   assign w_waddr = WA_W'(int'(req_data.row_index) * MAX_COLS + int'(req_data.col_index));
   assign w_raddr = WA_W'(int'(ctrl.row) * MAX_COLS + int'(col_ff));
   assign rd_row  = ctrl.row[RA_W-1:0];
   assign s_re    = ctrl.mac_rd || ctrl.out_rd;

   mvmb_ram #(.WIDTH(VAL_W), .DEPTH(W_DEPTH)) u_weight_ram (
      .clock (clock),
      .we    (w_we),
      .waddr (w_waddr),
      .wdata (req_data.value),
      .re    (ctrl.mac_rd),
      .raddr (w_raddr),
      .rdata (w_rdata)
   );

   mvmb_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ROWS)) u_bias_ram (
      .clock (clock),
      .we    (b_we),
      .waddr (req_data.row_index[RA_W-1:0]),
      .wdata (req_data.value),
      .re    (ctrl.out_rd),
      .raddr (rd_row),
      .rdata (b_rdata)
   );

   mvmb_ram #(.WIDTH(ACC_W), .DEPTH(MAX_ROWS)) u_sum_ram (
      .clock (clock),
      .we    (s2_vld_ff),
      .waddr (s2_row_ff),
      .wdata (s_wdata),
      .re    (s_re),
      .raddr (rd_row),
      .rdata (s_rdata)
   );

   assign sum_sel = sum_ok_ff ? s_rdata : '0;
   assign prod_in = $signed(w_rdata) * x_ff;
   assign s_wdata = acc_ff + {{(ACC_W - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};

   always_comb begin
      sum_vld_in = sum_vld_ff;
      if (s2_vld_ff) begin
         sum_vld_in[s2_row_ff] = 1'b1;
      end
      if (ctrl.clear_sums) begin
         sum_vld_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_vld_ff <= '0;
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
      end else begin
         sum_vld_ff <= sum_vld_in;
         s1_vld_ff  <= ctrl.mac_rd;
         s2_vld_ff  <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc && req_data.cmd == mvmb_pkg::CMD_VECTOR) begin
         x_ff   <= req_data.value;
         col_ff <= req_data.col_index;
      end
      if (s_re) begin
         sum_ok_ff <= sum_vld_ff[rd_row];
      end
      s1_row_ff <= rd_row;
      s2_row_ff <= s1_row_ff;
      prod_ff   <= prod_in;
      acc_ff    <= sum_sel;
   end

   assign fin_bias = bias_en ?
                     FIN_W'($signed({b_rdata, {FRAC_W{1'b0}}})) : '0;
   assign fin_sum  = $signed({sum_sel[ACC_W-1], sum_sel}) + fin_bias;
   assign q_val    = fin_sum[FIN_W-1:FRAC_W];

   always_comb begin
      if (!q_val[Q_W-1] && (|q_val[Q_W-2:VAL_W-1])) begin
         sat_val = {1'b0, {(VAL_W-1){1'b1}}};
      end else if (q_val[Q_W-1] && !(&q_val[Q_W-2:VAL_W-1])) begin
         sat_val = {1'b1, {(VAL_W-1){1'b0}}};
      end else begin
         sat_val = q_val[VAL_W-1:0];
      end
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff && rsp_stall;
      if (ctrl.out_load) begin
         rsp_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.out_load) begin
         rsp_ff.out_row      <= ctrl.row;
         rsp_ff.result_value <= sat_val;
         rsp_ff.last_of_run  <= ctrl.last_row;
      end
   end

   assign stat.pipe_busy = s1_vld_ff || s2_vld_ff;
   assign stat.out_free  = !rsp_vld_ff || !rsp_stall;
   assign rsp_valid      = rsp_vld_ff;
   assign rsp_data       = rsp_ff;

endmodule

// ----- src/mvmb_seq.sv -----
`timescale 1ns / 1ps

module mvmb_seq (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_acc,
   input  mvmb_pkg::req_type            req_data,
   input  logic                         col_in_use,
   input  logic [mvmb_pkg::NROWS_W-1:0] nrows,
   input  mvmb_pkg::stat_type           stat,
   output logic                         req_stall,
   output mvmb_pkg::ctrl_type           ctrl
);

   localparam int ROW_W = mvmb_pkg::ROW_W;

   mvmb_pkg::state_type state_ff;
   mvmb_pkg::state_type state_in;
   logic [ROW_W-1:0]    row_ff;
   logic [ROW_W-1:0]    row_in;
   logic                last_ff;
   logic                last_in;
   logic                at_last_row;

   assign at_last_row = {1'b0, row_ff} == nrows - 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mvmb_pkg::ST_IDLE;
         row_ff   <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         last_ff  <= last_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      row_in          = row_ff;
      last_in         = last_ff;
      req_stall       = 1'b1;
      ctrl            = '0;
      ctrl.row        = row_ff;
      ctrl.last_row   = at_last_row;
      case (state_ff)
         mvmb_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            row_in    = '0;
            if (req_acc && req_data.cmd == mvmb_pkg::CMD_VECTOR) begin
               last_in = req_data.last;
               if (col_in_use) begin
                  state_in = mvmb_pkg::ST_MAC;
               end else if (req_data.last) begin
                  state_in = mvmb_pkg::ST_OUT_READ;
               end
            end
         end
         mvmb_pkg::ST_MAC: begin
            ctrl.mac_rd = 1'b1;
            if (at_last_row) begin
               row_in   = '0;
               state_in = mvmb_pkg::ST_DRAIN;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end
         mvmb_pkg::ST_DRAIN: begin
            if (!stat.pipe_busy) begin
               state_in = last_ff ? mvmb_pkg::ST_OUT_READ : mvmb_pkg::ST_IDLE;
            end
         end
         mvmb_pkg::ST_OUT_READ: begin
            ctrl.out_rd = 1'b1;
            state_in    = mvmb_pkg::ST_OUT_LOAD;
         end
         mvmb_pkg::ST_OUT_LOAD: begin
            if (stat.out_free) begin
               ctrl.out_load = 1'b1;
               if (at_last_row) begin
                  ctrl.clear_sums = 1'b1;
                  row_in          = '0;
                  state_in        = mvmb_pkg::ST_IDLE;
               end else begin
                  row_in   = row_ff + 1'b1;
                  state_in = mvmb_pkg::ST_OUT_READ;
               end
            end
         end
         default: begin
            state_in = mvmb_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ----- src/matrix_vector_multiply_bias_unit.sv -----
`timescale 1ns / 1ps

// channel  direction  handshake              payload
// req      in         req_valid / req_stall  req_data (cmd, row_index, col_index, value, last)
// rsp      out        rsp_valid / rsp_stall  rsp_data (out_row, result_value, last_of_run)
// csr      in         csr_we                 csr_index, csr_wdata
//
// Weight and bias loads are written directly and leave the sequencer idle. A vector element inside the columns in use
// takes one shared multiply-accumulate pass per row, then a pipeline drain.
// An element marked last then emits one result per row from the row-sum memory read port.
// Reset clears row sums through per-row valid flags; weight and bias stores are not cleared.
// A stalled rsp holds the result; the next row waits in memory until the register frees up.

module matrix_vector_multiply_bias_unit #(
   parameter int MAX_ROWS = mvmb_pkg::MAX_ROWS_DEFAULT,
   parameter int MAX_COLS = mvmb_pkg::MAX_COLS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  mvmb_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output mvmb_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [mvmb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mvmb_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int NROWS_W = mvmb_pkg::NROWS_W;
   localparam int NCOLS_W = mvmb_pkg::NCOLS_W;
   localparam int NC_W    = $clog2(MAX_COLS + 1);

   logic [NROWS_W-1:0] rows_ff;
   logic [NCOLS_W-1:0] cols_ff;
   logic               bias_en_ff;
   logic [NROWS_W-1:0] nrows;
   logic [NC_W-1:0]    ncols;
   logic               col_in_use;
   logic               req_acc;
   mvmb_pkg::ctrl_type ctrl;
   mvmb_pkg::stat_type stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff    <= mvmb_pkg::ROWS_RESET;
         cols_ff    <= mvmb_pkg::COLS_RESET;
         bias_en_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            mvmb_pkg::CSR_ROWS_IN_USE: rows_ff    <= csr_wdata[NROWS_W-1:0];
            mvmb_pkg::CSR_COLS_IN_USE: cols_ff    <= csr_wdata[NCOLS_W-1:0];
            mvmb_pkg::CSR_BIAS_ENABLE: bias_en_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (rows_ff == '0) begin
         nrows = NROWS_W'(1);
      end else if (int'(rows_ff) > MAX_ROWS) begin
         nrows = NROWS_W'(MAX_ROWS);
      end else begin
         nrows = rows_ff;
      end
      if (cols_ff == '0) begin
         ncols = NC_W'(1);
      end else if (int'(cols_ff) > MAX_COLS) begin
         ncols = NC_W'(MAX_COLS);
      end else begin
         ncols = NC_W'(cols_ff);
      end
   end

   assign col_in_use = int'(req_data.col_index) < int'(ncols);
   assign req_acc    = req_valid && !req_stall;

   mvmb_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_acc    (req_acc),
      .req_data   (req_data),
      .col_in_use (col_in_use),
      .nrows      (nrows),
      .stat       (stat),
      .req_stall  (req_stall),
      .ctrl       (ctrl)
   );

   mvmb_datapath #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_acc   (req_acc),
      .req_data  (req_data),
      .bias_en   (bias_en_ff),
      .ctrl      (ctrl),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- src/mvmb_checker.sv -----
`timescale 1ns / 1ps

module mvmb_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input mvmb_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input mvmb_pkg::rsp_type rsp_data
);

   logic [mvmb_pkg::ROW_W-1:0] exp_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_row_ff <= '0;
      end else if (rsp_valid && !rsp_stall) begin
         exp_row_ff <= rsp_data.last_of_run ? '0 : exp_row_ff + 1'b1;
      end
   end

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp item changed");

   a_row_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.out_row == exp_row_ff)
      else $error("rsp rows out of order");

   a_load_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall &&
      (req_data.cmd == mvmb_pkg::CMD_WEIGHT || req_data.cmd == mvmb_pkg::CMD_BIAS)
      |=> !req_stall)
      else $error("load item did not complete in one cycle");

endmodule

bind matrix_vector_multiply_bias_unit mvmb_checker u_mvmb_checker (.*);

// ----- tb/tb_matrix_vector_multiply_bias_unit.sv -----
`timescale 1ns / 1ps

module tb_matrix_vector_multiply_bias_unit;
   import mvmb_pkg::*;

   localparam int N_ROWS = MAX_ROWS_DEFAULT;
   localparam int N_COLS = MAX_COLS_DEFAULT;
   localparam int SETTLE_CYCLES = 80;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor state
   logic signed [VAL_W-1:0] w_model [0:N_ROWS*N_COLS-1];
   logic signed [VAL_W-1:0] b_model [0:N_ROWS-1];
   logic [ACC_W-1:0] sum_model [0:N_ROWS-1];
   logic [NROWS_W-1:0] cfg_rows = ROWS_RESET;
   logic [NCOLS_W-1:0] cfg_cols = COLS_RESET;
   logic cfg_bias = 1'b0;

   // generator bookkeeping: store entries already given a value
   bit w_loaded [0:N_ROWS*N_COLS-1];
   bit b_loaded [0:N_ROWS-1];

   req_type req_backlog[$];
   rsp_type row_results_due[$];

   int items_queued = 0;
   int items_accepted = 0;
   int results_checked = 0;
   int fails = 0;
   int settings = 0;
   int burst_left = 0;
   int gap_left = 0;
   int stall_tick = 0;
   int quiet_cycles = 0;

   matrix_vector_multiply_bias_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic int eff_count(input int n, input int top);
      if (n == 0) return 1;
      return (n > top) ? top : n;
   endfunction

   function automatic void mvm_apply(input req_type it);
      int nr;
      int nc;
      int r;
      logic signed [ACC_W-1:0] prod;
      logic signed [ACC_W+1:0] total;
      logic signed [ACC_W+1:0] bterm;
      logic signed [ACC_W+1:0] q;
      rsp_type res;
      nr = eff_count(int'(cfg_rows), N_ROWS);
      nc = eff_count(int'(cfg_cols), N_COLS);
      case (it.cmd)
         CMD_WEIGHT: w_model[it.row_index * N_COLS + it.col_index] = it.value;
         CMD_BIAS: b_model[it.row_index] = it.value;
         CMD_VECTOR: begin
            if (it.col_index < nc) begin
               for (r = 0; r < nr; r++) begin
                  prod = ACC_W'($signed(w_model[r * N_COLS + it.col_index])) *
                         ACC_W'($signed(it.value));
                  sum_model[r] = sum_model[r] + prod;
               end
            end
            if (it.last) begin
               for (r = 0; r < nr; r++) begin
                  total = (ACC_W+2)'($signed(sum_model[r]));
                  if (cfg_bias) begin
                     bterm = (ACC_W+2)'($signed(b_model[r]));
                     total = total + (bterm <<< FRAC_W);
                  end
                  q = total >>> FRAC_W;
                  res.out_row = ROW_W'(r);
                  if (q > 32767) res.result_value = 16'sh7FFF;
                  else if (q < -32768) res.result_value = 16'sh8000;
                  else res.result_value = q[VAL_W-1:0];
                  res.last_of_run = (r == nr - 1);
                  row_results_due.insert(row_results_due.size(), res);
               end
               foreach (sum_model[i]) sum_model[i] = '0;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic logic [VAL_W-1:0] rand_value();
      case ($urandom_range(0, 7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3, 4, 5: return 16'($urandom_range(0, 2047)) - 16'd1024;
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic int missing_weights(input int c, input int nr);
      int r;
      int n;
      n = 0;
      for (r = 0; r < nr; r++)
         if (!w_loaded[r * N_COLS + c]) n++;
      return n;
   endfunction

   task automatic queue_item(input logic [CMD_W-1:0] cmd, input int row, input int col,
                             input logic [VAL_W-1:0] val, input logic mark);
      req_type it;
      it.cmd = cmd;
      it.row_index = ROW_W'(row);
      it.col_index = COL_W'(col);
      it.value = val;
      it.last = mark;
      if (cmd == CMD_WEIGHT) w_loaded[row * N_COLS + col] = 1'b1;
      else if (cmd == CMD_BIAS) b_loaded[row] = 1'b1;
      if (cmd != CMD_UNUSED) items_queued++;
      req_backlog.insert(req_backlog.size(), it);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (req_backlog.size() != 0 || req_valid || row_results_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(data);
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_ROWS_IN_USE: cfg_rows = NROWS_W'(data);
         CSR_COLS_IN_USE: cfg_cols = NCOLS_W'(data);
         CSR_BIAS_ENABLE: cfg_bias = data[0];
         default: ;
      endcase
   endtask

   task automatic set_config(input int rows, input int cols, input bit bias_on);
      wait_idle();
      write_reg(CSR_ROWS_IN_USE, rows);
      write_reg(CSR_COLS_IN_USE, cols);
      write_reg(CSR_BIAS_ENABLE, int'(bias_on));
      settings++;
      @(negedge clock);
   endtask

   task automatic run_phase(input int rows, input int cols, input bit bias_on, input int budget);
      int nr;
      int nc;
      int k;
      int c;
      int best;
      int best_miss;
      int miss;
      int n_el;
      int r;
      int i;
      int start;
      int picks[$];
      set_config(rows, cols, bias_on);
      nr = eff_count(rows, N_ROWS);
      nc = eff_count(cols, N_COLS);
      start = items_queued;
      while (items_queued - start < budget) begin
         picks.delete();
         k = $urandom_range(1, 3);
         repeat (k) begin
            if (nc < N_COLS && $urandom_range(0, 3) == 0) begin
               c = $urandom_range(nc, N_COLS - 1);
            end else begin
               c = $urandom_range(0, nc - 1);
               // prefer a column that is already mostly loaded
               if (missing_weights(c, nr) > 8) begin
                  best = 0;
                  best_miss = nr + 1;
                  for (i = 0; i < nc; i++) begin
                     miss = missing_weights(i, nr);
                     if (miss < best_miss) begin
                        best_miss = miss;
                        best = i;
                     end
                  end
                  c = best;
               end
               for (r = 0; r < nr; r++)
                  if (!w_loaded[r * N_COLS + c])
                     queue_item(CMD_WEIGHT, r, c, rand_value(), 1'($urandom_range(0, 1)));
               if ($urandom_range(0, 1) == 0)
                  queue_item(CMD_WEIGHT, $urandom_range(0, nr - 1), c, rand_value(), 1'b0);
            end
            picks.insert(picks.size(), c);
         end
         if (bias_on) begin
            for (r = 0; r < nr; r++)
               if (!b_loaded[r])
                  queue_item(CMD_BIAS, r, 0, rand_value(), 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 1) == 0)
               queue_item(CMD_BIAS, $urandom_range(0, nr - 1), $urandom_range(0, N_COLS - 1),
                          rand_value(), 1'b0);
         end
         case ($urandom_range(0, 2))
            0: queue_item(CMD_UNUSED, $urandom_range(0, N_ROWS - 1), $urandom_range(0, N_COLS - 1),
                          16'($urandom()), 1'($urandom_range(0, 1)));
            1: queue_item($urandom_range(0, 1) ? CMD_BIAS : CMD_WEIGHT, $urandom_range(0, N_ROWS - 1),
                          $urandom_range(0, N_COLS - 1), rand_value(), 1'($urandom_range(0, 1)));
            default: ;
         endcase
         // leave the vector open now and then so it carries into the next one
         n_el = $urandom_range(1, 6);
         for (i = 0; i < n_el; i++)
            queue_item(CMD_VECTOR, $urandom_range(0, N_ROWS - 1),
                       picks[$urandom_range(0, picks.size() - 1)], rand_value(),
                       (i == n_el - 1) && ($urandom_range(0, 7) != 0));
      end
   endtask

   // driver: bursts of items with random gaps
   always @(posedge clock) begin
      logic take;
      logic send;
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         take = req_valid && !req_stall;
         if (take) begin
            mvm_apply(req_data);
            items_accepted++;
         end
         send = req_valid && !take;
         if (!send) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (req_backlog.size() != 0) begin
               req_data <= req_backlog.pop_front();
               send = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 15);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
               end
            end
         end
         req_valid <= send;
      end
   end

   // monitor: check row results and stall in rotating modes
   always @(posedge clock) begin
      rsp_type want;
      logic stall_next;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (row_results_due.size() == 0) begin
               $error("result with no item pending: out_row %0d result_value %0d",
                      rsp_data.out_row, rsp_data.result_value);
               fails++;
            end else begin
               want = row_results_due.pop_front();
               if (rsp_data.out_row !== want.out_row) begin
                  $error("out_row: expected %0d, got %0d", want.out_row, rsp_data.out_row);
                  fails++;
               end
               if (rsp_data.result_value !== want.result_value) begin
                  $error("result_value: expected %0d, got %0d",
                         want.result_value, rsp_data.result_value);
                  fails++;
               end
               if (rsp_data.last_of_run !== want.last_of_run) begin
                  $error("last_of_run: expected %0d, got %0d",
                         want.last_of_run, rsp_data.last_of_run);
                  fails++;
               end
            end
         end
         stall_tick++;
         case ((stall_tick / 256) % 3)
            0: stall_next = 1'b0;
            1: stall_next = ($urandom_range(0, 2) == 0);
            default: stall_next = ((stall_tick % 11) < 4);
         endcase
         rsp_stall <= stall_next;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      foreach (sum_model[i]) sum_model[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // extremes, saturation both ways, ignored command, last on loads
      set_config(2, 2, 1'b1);
      queue_item(CMD_WEIGHT, 0, 0, 16'h7FFF, 1'b0);
      queue_item(CMD_WEIGHT, 1, 0, 16'h8000, 1'b0);
      queue_item(CMD_WEIGHT, 0, 1, 16'h0100, 1'b0);
      queue_item(CMD_WEIGHT, 1, 1, 16'hFFFF, 1'b1);
      queue_item(CMD_BIAS, 0, 0, 16'h7FFF, 1'b0);
      queue_item(CMD_BIAS, 1, 0, 16'h8000, 1'b1);
      queue_item(CMD_UNUSED, N_ROWS - 1, N_COLS - 1, 16'hFFFF, 1'b1);
      queue_item(CMD_VECTOR, 0, 0, 16'h7FFF, 1'b0);
      queue_item(CMD_VECTOR, 0, 1, 16'h8000, 1'b0);
      queue_item(CMD_VECTOR, N_ROWS - 1, N_COLS - 1, 16'h7FFF, 1'b1);
      queue_item(CMD_VECTOR, 0, 0, 16'h0000, 1'b1);
      queue_item(CMD_WEIGHT, N_ROWS - 1, N_COLS - 1, 16'h1234, 1'b1);

      // floor rounding of a small negative sum, then hold a vector open
      set_config(2, 2, 1'b0);
      queue_item(CMD_VECTOR, 0, 1, 16'h0001, 1'b1);
      queue_item(CMD_VECTOR, 0, 0, 16'h0100, 1'b0);

      // zero counts act as one; change settings mid-vector
      set_config(0, 0, 1'b0);
      queue_item(CMD_VECTOR, 0, 1, 16'h0005, 1'b1);

      run_phase(5, 16, 1'b1, 8);
      run_phase(1, 256, 1'b0, 8);
      run_phase(127, 2, 1'b0, 8);
      run_phase(64, 511, 1'b0, 8);
      run_phase(0, 1, 1'b1, 8);
      run_phase(13, 40, 1'b1, 8);
      wait_idle();

      $display("Run covered %0d accepted items and %0d checked row results", items_accepted,
               results_checked);
      $display("across %0d register settings: 1 to 64 rows, 1 to 256 columns, bias on and off",
               settings);
      if (fails == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- matrix_vector_multiply_bias_unit.f -----
src/mvmb_pkg.sv
src/mvmb_ram.sv
src/mvmb_datapath.sv
src/mvmb_seq.sv
src/matrix_vector_multiply_bias_unit.sv
src/mvmb_checker.sv
tb/tb_matrix_vector_multiply_bias_unit.sv
